/* hw/rtl/tpmt_pkg.sv */
package tpmt_pkg;

  localparam int unsigned ENTRIES_DEF     = 32;
  localparam int unsigned KEY_BITS_DEF    = 64;
  localparam int unsigned PRIO_BITS_DEF   = 16;
  localparam int unsigned ACTION_BITS_DEF = 16;
  localparam int unsigned NEXT_BITS_DEF   = 8;

  localparam int unsigned HANDLE_W    = 5;
  localparam int unsigned LIMIT_W     = 6;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_MODIFY = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_BAD_HANDLE = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TABLE_LIMIT    = 2'd0,
    CFG_DEFAULT_ACTION = 2'd1,
    CFG_DEFAULT_NEXT   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    mode_e        mode;
    logic [63:0]  key;
    logic [63:0]  mask;
    logic [15:0]  priority_req;
    logic [4:0]   handle;
    logic [15:0]  action_id;
    logic [7:0]   next_hop;
  } req_t;

  typedef struct packed {
    status_e      status;
    logic         hit;
    logic [4:0]   out_handle;
    logic [15:0]  out_action;
    logic [7:0]   out_next;
  } res_t;

  typedef struct packed {
    logic tok;
    logic found;
  } chain_t;

endpackage

/* hw/rtl/tpmt_cell.sv */
module tpmt_cell import tpmt_pkg::*; #(
  parameter int unsigned IDX         = 0,
  parameter int unsigned KEY_BITS    = KEY_BITS_DEF,
  parameter int unsigned PRIO_BITS   = PRIO_BITS_DEF,
  parameter int unsigned ACTION_BITS = ACTION_BITS_DEF,
  parameter int unsigned NEXT_BITS   = NEXT_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  req_t                   req_i,
  input  logic                   add_ok_i,
  input  chain_t                 chain_i,
  input  logic [PRIO_BITS-1:0]   prio_i,
  input  logic [HANDLE_W-1:0]    handle_i,
  input  logic [ACTION_BITS-1:0] act_i,
  input  logic [NEXT_BITS-1:0]   next_i,
  output chain_t                 chain_o,
  output logic [PRIO_BITS-1:0]   prio_o,
  output logic [HANDLE_W-1:0]    handle_o,
  output logic [ACTION_BITS-1:0] act_o,
  output logic [NEXT_BITS-1:0]   next_o
);

  logic                   valid_q, valid_d;
  logic [KEY_BITS-1:0]    key_q;
  logic [KEY_BITS-1:0]    mask_q;
  logic [PRIO_BITS-1:0]   prio_q;
  logic [ACTION_BITS-1:0] act_q;
  logic [NEXT_BITS-1:0]   next_q;

  chain_t                 chain_q, chain_d;
  logic [PRIO_BITS-1:0]   bprio_q, bprio_d;
  logic [HANDLE_W-1:0]    bhandle_q, bhandle_d;
  logic [ACTION_BITS-1:0] bact_q, bact_d;
  logic [NEXT_BITS-1:0]   bnext_q, bnext_d;

  logic wr_entry;
  logic wr_data;
  logic hsel;
  logic key_match;

  assign hsel      = (32'(req_i.handle) == 32'(IDX));
  assign key_match = (key_q == (KEY_BITS'(req_i.key) & mask_q));

  always_comb begin
    chain_d   = chain_i;
    bprio_d   = prio_i;
    bhandle_d = handle_i;
    bact_d    = act_i;
    bnext_d   = next_i;
    valid_d   = valid_q;
    wr_entry  = 1'b0;
    wr_data   = 1'b0;
    if (chain_i.tok) begin
      unique case (req_i.mode)
        MODE_LOOKUP: begin
          if (valid_q && (prio_q > prio_i) && key_match) begin
            chain_d.found = 1'b1;
            bprio_d       = prio_q;
            bhandle_d     = HANDLE_W'(IDX);
            bact_d        = act_q;
            bnext_d       = next_q;
          end
        end
        MODE_ADD: begin
          if (add_ok_i && !chain_i.found && !valid_q) begin
            chain_d.found = 1'b1;
            bhandle_d     = HANDLE_W'(IDX);
            valid_d       = 1'b1;
            wr_entry      = 1'b1;
          end
        end
        MODE_DELETE: begin
          if (hsel && valid_q) begin
            chain_d.found = 1'b1;
            valid_d       = 1'b0;
          end
        end
        MODE_MODIFY: begin
          if (hsel && valid_q) begin
            chain_d.found = 1'b1;
            wr_data       = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      chain_q <= '0;
    end else begin
      valid_q <= valid_d;
      chain_q <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bprio_q   <= bprio_d;
    bhandle_q <= bhandle_d;
    bact_q    <= bact_d;
    bnext_q   <= bnext_d;
    if (wr_entry) begin
      key_q  <= KEY_BITS'(req_i.key);
      mask_q <= KEY_BITS'(req_i.mask);
      prio_q <= PRIO_BITS'(req_i.priority_req);
    end
    if (wr_entry || wr_data) begin
      act_q  <= ACTION_BITS'(req_i.action_id);
      next_q <= NEXT_BITS'(req_i.next_hop);
    end
  end

  assign chain_o  = chain_q;
  assign prio_o   = bprio_q;
  assign handle_o = bhandle_q;
  assign act_o    = bact_q;
  assign next_o   = bnext_q;

endmodule

/* hw/rtl/priority_ternary_match_table_core.sv */
// An accepted start is registered into inj_q; done_o strobes when the token leaves the last cell.
// A new operation is accepted only after done_o; busy stays high through the done cycle.
// The operation token walks the row of entry cells, one cell per cycle.
// Reset clears all entry valid bits and the entry count, sets table_limit to 32
// and both defaults to 0; there is no clearing pass.
// The result is valid for the single done_o cycle; the receiver cannot stall.
module priority_ternary_match_table_core import tpmt_pkg::*; #(
  parameter int unsigned ENTRIES     = ENTRIES_DEF,
  parameter int unsigned KEY_BITS    = KEY_BITS_DEF,
  parameter int unsigned PRIO_BITS   = PRIO_BITS_DEF,
  parameter int unsigned ACTION_BITS = ACTION_BITS_DEF,
  parameter int unsigned NEXT_BITS   = NEXT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  req_t                  req_i,
  output logic                  done_o,
  output res_t                  result_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  logic                   busy_q, busy_d;
  logic                   inj_q;
  req_t                   req_q;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [LIMIT_W-1:0]     limit_q;
  logic [ACTION_BITS-1:0] def_act_q;
  logic [NEXT_BITS-1:0]   def_next_q;
  logic                   accept;
  logic                   add_ok;

  chain_t                 chain   [ENTRIES+1];
  logic [PRIO_BITS-1:0]   bprio   [ENTRIES+1];
  logic [HANDLE_W-1:0]    bhandle [ENTRIES+1];
  logic [ACTION_BITS-1:0] bact    [ENTRIES+1];
  logic [NEXT_BITS-1:0]   bnext   [ENTRIES+1];
  logic [ENTRIES-1:0]     tok_vec;

  chain_t last;

  assign accept      = start && !busy_q;
  assign busy        = busy_q;
  assign cfg_ready_o = 1'b1;
  assign add_ok      = (CMP_W'(count_q) < CMP_W'(limit_q));

  assign chain[0].tok   = inj_q;
  assign chain[0].found = 1'b0;
  assign bprio[0]       = '0;
  assign bhandle[0]     = '0;
  assign bact[0]        = '0;
  assign bnext[0]       = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    tpmt_cell #(
      .IDX         (g),
      .KEY_BITS    (KEY_BITS),
      .PRIO_BITS   (PRIO_BITS),
      .ACTION_BITS (ACTION_BITS),
      .NEXT_BITS   (NEXT_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .req_i    (req_q),
      .add_ok_i (add_ok),
      .chain_i  (chain[g]),
      .prio_i   (bprio[g]),
      .handle_i (bhandle[g]),
      .act_i    (bact[g]),
      .next_i   (bnext[g]),
      .chain_o  (chain[g+1]),
      .prio_o   (bprio[g+1]),
      .handle_o (bhandle[g+1]),
      .act_o    (bact[g+1]),
      .next_o   (bnext[g+1])
    );
    assign tok_vec[g] = chain[g+1].tok;
  end

  assign last   = chain[ENTRIES];
  assign done_o = last.tok;

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (last.tok) begin
      busy_d = 1'b0;
    end
  end

  always_comb begin
    count_d = count_q;
    if (last.tok && last.found) begin
      unique case (req_q.mode)
        MODE_ADD:    count_d = count_q + CNT_W'(1);
        MODE_DELETE: count_d = count_q - CNT_W'(1);
        default:     count_d = count_q;
      endcase
    end
  end

  always_comb begin
    result_o = '0;
    unique case (req_q.mode)
      MODE_LOOKUP: begin
        result_o.status = ST_OK;
        if (last.found) begin
          result_o.hit        = 1'b1;
          result_o.out_handle = bhandle[ENTRIES];
          result_o.out_action = 16'(bact[ENTRIES]);
          result_o.out_next   = 8'(bnext[ENTRIES]);
        end else begin
          result_o.out_action = 16'(def_act_q);
          result_o.out_next   = 8'(def_next_q);
        end
      end
      MODE_ADD: begin
        if (last.found) begin
          result_o.status     = ST_OK;
          result_o.out_handle = bhandle[ENTRIES];
        end else begin
          result_o.status = ST_FULL;
        end
      end
      default: begin
        result_o.status = last.found ? ST_OK : ST_BAD_HANDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      inj_q   <= 1'b0;
      count_q <= '0;
    end else begin
      busy_q  <= busy_d;
      inj_q   <= accept;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q    <= LIMIT_RESET;
      def_act_q  <= '0;
      def_next_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_TABLE_LIMIT:    limit_q    <= LIMIT_W'(cfg_data_i);
        CFG_DEFAULT_ACTION: def_act_q  <= ACTION_BITS'(cfg_data_i);
        CFG_DEFAULT_NEXT:   def_next_q <= NEXT_BITS'(cfg_data_i);
        default: begin
        end
      endcase
    end
  end

  a_done_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_q)
    else $error("done strobe outside an operation");

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({tok_vec, inj_q}))
    else $error("more than one operation token in the cell row");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(ENTRIES))
    else $error("entry count above table size");

  a_hit_only_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.hit) |-> (req_q.mode == MODE_LOOKUP))
    else $error("hit reported for a non-lookup transfer");

  a_accept_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy_q && inj_q))
    else $error("accepted transfer did not enter the cell row");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import tpmt_pkg::*;

  localparam int unsigned TBL_DEPTH      = ENTRIES_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS    = 10;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  start       = 1'b0;
  logic                  busy;
  req_t                  req_i       = '0;
  logic                  done_o;
  res_t                  result_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  // Shadow copy of the table and its registers, updated at each transfer.
  logic [63:0]        shadow_key   [TBL_DEPTH];
  logic [63:0]        shadow_mask  [TBL_DEPTH];
  logic [15:0]        shadow_prio  [TBL_DEPTH];
  logic [15:0]        shadow_act   [TBL_DEPTH];
  logic [7:0]         shadow_next  [TBL_DEPTH];
  logic               shadow_valid [TBL_DEPTH] = '{default: 1'b0};
  int unsigned        live_count   = 0;
  logic [LIMIT_W-1:0] table_limit  = LIMIT_RESET;
  logic [15:0]        dflt_action  = '0;
  logic [7:0]         dflt_next    = '0;

  res_t        pending_results [$];
  int unsigned mismatch_cnt  = 0;
  int unsigned quiet_cycles  = 0;
  bit          sender_idles  = 1'b0;

  priority_ternary_match_table_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic res_t predict_table_op(req_t op);
    res_t        r;
    int          best;
    logic [15:0] best_prio;
    r = '0;
    r.status = ST_OK;
    best = -1;
    best_prio = '0;
    case (op.mode)
      MODE_LOOKUP: begin
        for (int i = 0; i < TBL_DEPTH; i++) begin
          if (shadow_valid[i] && shadow_prio[i] > best_prio &&
              shadow_key[i] == (op.key & shadow_mask[i])) begin
            best = i;
            best_prio = shadow_prio[i];
          end
        end
        if (best >= 0) begin
          r.hit = 1'b1;
          r.out_handle = 5'(best);
          r.out_action = shadow_act[best];
          r.out_next = shadow_next[best];
        end else begin
          r.out_action = dflt_action;
          r.out_next = dflt_next;
        end
      end
      MODE_ADD: begin
        if (live_count < table_limit) begin
          for (int i = TBL_DEPTH - 1; i >= 0; i--) begin
            if (!shadow_valid[i]) best = i;
          end
        end
        if (best < 0) begin
          r.status = ST_FULL;
        end else begin
          shadow_key[best] = op.key;
          shadow_mask[best] = op.mask;
          shadow_prio[best] = op.priority_req;
          shadow_act[best] = op.action_id;
          shadow_next[best] = op.next_hop;
          shadow_valid[best] = 1'b1;
          live_count++;
          r.out_handle = 5'(best);
        end
      end
      MODE_DELETE: begin
        if (!shadow_valid[op.handle]) begin
          r.status = ST_BAD_HANDLE;
        end else begin
          shadow_valid[op.handle] = 1'b0;
          if (live_count > 0) live_count--;
        end
      end
      MODE_MODIFY: begin
        if (!shadow_valid[op.handle]) begin
          r.status = ST_BAD_HANDLE;
        end else begin
          shadow_act[op.handle] = op.action_id;
          shadow_next[op.handle] = op.next_hop;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void report_mismatch(string what, res_t want, res_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) begin
      $display("%0t %s: expected status=%0d hit=%0d handle=%0d action=%h next=%h",
               $realtime, what, want.status, want.hit, want.out_handle, want.out_action,
               want.out_next);
      $display("%0t %s: actual   status=%0d hit=%0d handle=%0d action=%h next=%h",
               $realtime, what, got.status, got.hit, got.out_handle, got.out_action,
               got.out_next);
    end
  endfunction

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", '0, result_o);
      end else begin
        want = pending_results.pop_front();
        if (result_o.status !== want.status || result_o.hit !== want.hit ||
            result_o.out_handle !== want.out_handle ||
            result_o.out_action !== want.out_action ||
            result_o.out_next !== want.out_next) begin
          report_mismatch("result mismatch", want, result_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pick_mask();
    case ($urandom_range(0, 3))
      0: return '1;
      1: return '0;
      2: return ~64'h0 << (8 * $urandom_range(1, 7));
      default: return rand64();
    endcase
  endfunction

  function automatic int pick_live_handle();
    int base;
    base = $urandom_range(0, TBL_DEPTH - 1);
    for (int i = 0; i < TBL_DEPTH; i++) begin
      if (shadow_valid[(base + i) % TBL_DEPTH]) return (base + i) % TBL_DEPTH;
    end
    return -1;
  endfunction

  function automatic req_t make_op(mode_e m, logic [63:0] key, logic [63:0] mask,
                                   logic [15:0] prio, logic [4:0] h, logic [15:0] act,
                                   logic [7:0] nxt);
    req_t op;
    op.mode = m;
    op.key = key;
    op.mask = mask;
    op.priority_req = prio;
    op.handle = h;
    op.action_id = act;
    op.next_hop = nxt;
    return op;
  endfunction

  function automatic req_t random_op(int unsigned add_pct, int unsigned del_pct);
    req_t        op;
    int          h;
    int unsigned roll;
    op = make_op(MODE_LOOKUP, rand64(), rand64(), 16'($urandom()), 5'($urandom()),
                 16'($urandom()), 8'($urandom()));
    roll = $urandom_range(0, 99);
    h = pick_live_handle();
    if (roll < add_pct) begin
      op.mode = MODE_ADD;
      op.mask = pick_mask();
      if ($urandom_range(0, 4) != 0) op.key = op.key & op.mask;
      if ($urandom_range(0, 9) < 6) op.priority_req = 16'($urandom_range(0, 3));
    end else if (roll < add_pct + del_pct) begin
      op.mode = MODE_DELETE;
      if (h >= 0 && $urandom_range(0, 3) != 0) op.handle = 5'(h);
    end else if (roll < add_pct + del_pct + 10) begin
      op.mode = MODE_MODIFY;
      if (h >= 0 && $urandom_range(0, 3) != 0) op.handle = 5'(h);
    end else if (h >= 0 && $urandom_range(0, 9) < 7) begin
      // Build a key from the chosen entry's key, with noise on its don't-care bits.
      op.key = shadow_key[h] | (op.key & ~shadow_mask[h]);
    end
    return op;
  endfunction

  // Start stays high after a transfer so that the next operation can follow
  // without a bubble; callers that wait lower it first.
  task automatic send_op(req_t op);
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      @(posedge clk_i);
      while (busy) @(posedge clk_i);
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= op;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_results.push_back(predict_table_op(op));
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_TABLE_LIMIT:    table_limit = val[LIMIT_W-1:0];
      CFG_DEFAULT_ACTION: dflt_action = val;
      CFG_DEFAULT_NEXT:   dflt_next = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [LIMIT_W-1:0] limit, logic [15:0] act, logic [7:0] nxt);
    drain_results();
    write_reg(CFG_TABLE_LIMIT, 16'(limit));
    write_reg(CFG_DEFAULT_ACTION, act);
    write_reg(CFG_DEFAULT_NEXT, 16'(nxt));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_directed_ops();
    sender_idles = 1'b1;
    send_op(make_op(MODE_LOOKUP, '0, '0, '0, '0, '0, '0));
    set_config(6'd32, 16'hFFFF, 8'hFF);
    send_op(make_op(MODE_LOOKUP, '1, '1, '1, '1, '1, '1));
    send_op(make_op(MODE_ADD, '1, '1, 16'hFFFF, '0, 16'hFFFF, 8'hFF));
    send_op(make_op(MODE_ADD, '0, '0, 16'd1, '1, 16'h0001, 8'h01));
    // Priority zero never wins a lookup.
    send_op(make_op(MODE_ADD, '0, '0, 16'd0, '0, 16'h0002, 8'h02));
    // Stored key has a bit set outside its mask, so it can never match.
    send_op(make_op(MODE_ADD, 64'h1, '0, 16'hFFFF, '0, 16'h0003, 8'h03));
    send_op(make_op(MODE_ADD, '0, '0, 16'd1, '0, 16'h0004, 8'h04));
    send_op(make_op(MODE_LOOKUP, '1, '0, '0, '0, '0, '0));
    send_op(make_op(MODE_LOOKUP, '0, '0, '0, '0, '0, '0));
    send_op(make_op(MODE_LOOKUP, 64'h5, '1, '1, '1, '1, '1));
    send_op(make_op(MODE_MODIFY, '1, '1, '1, 5'd1, '0, '0));
    send_op(make_op(MODE_LOOKUP, 64'h10, '0, '0, '0, '0, '0));
    send_op(make_op(MODE_DELETE, '0, '0, '0, 5'd1, '0, '0));
    send_op(make_op(MODE_LOOKUP, '0, '0, '0, '0, '0, '0));
    send_op(make_op(MODE_DELETE, '1, '1, '1, 5'd1, '1, '1));
    send_op(make_op(MODE_MODIFY, '0, '0, '0, 5'd31, 16'h1234, 8'h56));
    send_op(make_op(MODE_DELETE, '0, '0, '0, 5'd31, '0, '0));
    send_op(make_op(MODE_ADD, '0, 64'hFFFF_FFFF_FFFF_FF00, 16'd2, 5'd31, 16'hBEEF, 8'h7E));
    send_op(make_op(MODE_LOOKUP, 64'h0F, '0, '0, '0, '0, '0));
    send_op(make_op(MODE_DELETE, '0, '0, '0, 5'd0, '0, '0));
    send_op(make_op(MODE_LOOKUP, '1, '0, '0, '0, '0, '0));
    drain_results();
  endtask

  task automatic test_table_limit();
    set_config(6'd0, 16'h0000, 8'h00);
    send_op(make_op(MODE_ADD, '0, '1, 16'd9, '0, 16'h1111, 8'h11));
    send_op(make_op(MODE_LOOKUP, 64'hDEAD_BEEF_0000_0001, '0, '0, '0, '0, '0));
    set_config(6'(live_count + 1), 16'h5A5A, 8'hA5);
    send_op(make_op(MODE_ADD, 64'h00FF, '1, 16'd7, '0, 16'h2222, 8'h22));
    send_op(make_op(MODE_ADD, 64'h0F0F, '1, 16'd7, '0, 16'h3333, 8'h33));
    send_op(make_op(MODE_LOOKUP, 64'h00FF, '0, '0, '0, '0, '0));
    drain_results();
  endtask

  task automatic test_random_traffic(int unsigned n, logic [LIMIT_W-1:0] limit,
                                     int unsigned add_pct, int unsigned del_pct, bit idles);
    set_config(limit, 16'($urandom()), 8'($urandom()));
    sender_idles = idles;
    repeat (n) send_op(random_op(add_pct, del_pct));
    drain_results();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_ops();
    test_table_limit();
    test_random_traffic(230, 6'd63, 45, 10, 1'b1);
    test_random_traffic(230, 6'd32, 25, 25, 1'b1);
    test_random_traffic(230, 6'd5, 30, 30, 1'b1);
    test_random_traffic(230, 6'd20, 20, 35, 1'b1);
    test_random_traffic(200, 6'd1, 30, 20, 1'b1);
    test_random_traffic(230, 6'd32, 30, 15, 1'b1);
    test_random_traffic(200, 6'd32, 25, 20, 1'b0);
    drain_results();
    repeat (TBL_DEPTH + 8) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/tpmt_pkg.sv
hw/rtl/tpmt_cell.sv
hw/rtl/priority_ternary_match_table_core.sv
dv/tb_top.sv
